/* sv/mpvd_pkg.sv */
`default_nettype none
package mpvd_pkg;

    localparam int unsigned CNT_W = 33;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_POP,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_ARRAY = 2'd1,
        KIND_MAP   = 2'd2
    } kind_t;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_TAG  = 2'd1;
    localparam logic [1:0] STAT_TRUNC    = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW = 2'd3;

    // tag decode actions
    typedef enum logic [2:0] {
        ACT_SCALAR,
        ACT_OPEN,
        ACT_BODY,
        ACT_LEN,
        ACT_BAD
    } act_t;

    typedef struct packed {
        act_t        act;
        logic [5:0]  count;   // container count or body size
        logic [2:0]  nbytes;
        kind_t       kind;
        logic        ext;
    } tag_dec_t;

    function automatic logic [4:0] fixed_size(input logic [7:0] c);
        logic [4:0] r;
        begin
            case (c)
                8'hca: r = 5'd4;
                8'hcb: r = 5'd8;
                8'hcc: r = 5'd1;
                8'hcd: r = 5'd2;
                8'hce: r = 5'd4;
                8'hcf: r = 5'd8;
                8'hd0: r = 5'd1;
                8'hd1: r = 5'd2;
                8'hd2: r = 5'd4;
                8'hd3: r = 5'd8;
                8'hd4: r = 5'd2;
                8'hd5: r = 5'd3;
                8'hd6: r = 5'd5;
                8'hd7: r = 5'd9;
                8'hd8: r = 5'd17;
                default: r = 5'd0;
            endcase
            fixed_size = r;
        end
    endfunction

    function automatic tag_dec_t decode_tag(input logic [7:0] c);
        tag_dec_t d;
        begin
            d = '{act: ACT_BAD, count: 6'd0, nbytes: 3'd0, kind: KIND_BODY, ext: 1'b0};
            if (c <= 8'h7f || c >= 8'he0) begin
                d.act = ACT_SCALAR;
            end else if ((c & 8'hf0) == 8'h80) begin
                d.act = ACT_OPEN;
                d.count = {1'b0, c[3:0], 1'b0};
            end else if ((c & 8'hf0) == 8'h90) begin
                d.act = ACT_OPEN;
                d.count = {2'b00, c[3:0]};
            end else if ((c & 8'he0) == 8'ha0) begin
                d.act = ACT_BODY;
                d.count = {1'b0, c[4:0]};
            end else if (c >= 8'hca && c <= 8'hd8) begin
                d.act = ACT_BODY;
                d.count = {1'b0, fixed_size(c)};
            end else begin
                case (c)
                    8'hc0, 8'hc2, 8'hc3: d.act = ACT_SCALAR;
                    8'hc4, 8'hd9: begin d.act = ACT_LEN; d.nbytes = 3'd1; end
                    8'hc5, 8'hda: begin d.act = ACT_LEN; d.nbytes = 3'd2; end
                    8'hc6, 8'hdb: begin d.act = ACT_LEN; d.nbytes = 3'd4; end
                    8'hc7: begin d.act = ACT_LEN; d.nbytes = 3'd1; d.ext = 1'b1; end
                    8'hc8: begin d.act = ACT_LEN; d.nbytes = 3'd2; d.ext = 1'b1; end
                    8'hc9: begin d.act = ACT_LEN; d.nbytes = 3'd4; d.ext = 1'b1; end
                    8'hdc: begin d.act = ACT_LEN; d.nbytes = 3'd2; d.kind = KIND_ARRAY; end
                    8'hdd: begin d.act = ACT_LEN; d.nbytes = 3'd4; d.kind = KIND_ARRAY; end
                    8'hde: begin d.act = ACT_LEN; d.nbytes = 3'd2; d.kind = KIND_MAP; end
                    8'hdf: begin d.act = ACT_LEN; d.nbytes = 3'd4; d.kind = KIND_MAP; end
                    default: d.act = ACT_BAD;
                endcase
            end
            decode_tag = d;
        end
    endfunction

    // controller to datapath
    typedef struct packed {
        logic take_byte;   // latch input byte and frame flag
        logic do_byte;     // process the latched byte
        logic do_pop;      // one stack pop step
        logic frame_end;   // apply frame end check (the clear comes with out_load)
        logic out_load;    // load the result register
    } mpvd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pop_pending;
    } mpvd_stat_t;

endpackage
`default_nettype wire

/* sv/msgpack_value_delimiter_core.sv */
`default_nettype none
// messagepack value delimiter
// input channel s_valid/s_ready carries one document byte per request
// (s_data_byte) and s_frame_last marking the last byte of the buffer
// output channel m_valid/m_ready returns exactly one result per request:
// m_value_done when the byte closes a top-level value, m_status (0 ok,
// 1 invalid tag, 2 truncated, 3 nesting overflow, sticky until frame end)
// and m_nest_level, the open container levels after the byte
// after acceptance a request passes the work, pop and fin states; a byte
// that completes an item inside a container also runs the pop loop, which
// updates the top count and closes each exhausted nesting level, walking
// the stack a level a cycle; no new byte is taken before the result is
// loaded, the next request being taken the cycle after the result is loaded
// a new byte is taken while the previous result still waits in the
// output register; if the receiver stalls, the block holds the next
// result in its final state until the register frees
// synchronous active-low reset returns the parser to expecting a tag with
// no open levels and no error; the count stack itself is not cleared
module msgpack_value_delimiter_core
    import mpvd_pkg::*;
#(
    parameter int unsigned MAX_NEST = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_frame_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_value_done,
    output logic [1:0]      m_status,
    output logic [4:0]      m_nest_level
);
    mpvd_cmd_t  cmd;
    mpvd_stat_t stat;

    // sequencing of one request
    mpvd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // parser state, count stack and result register
    mpvd_datapath #(
        .MAX_NEST (MAX_NEST)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_byte  (s_data_byte),
        .in_last  (s_frame_last),
        .done_o   (m_value_done),
        .status_o (m_status),
        .level_o  (m_nest_level)
    );

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while busy");
    a_stable_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_status) && $stable(m_nest_level))
        else $error("stalled result changed");
    a_done_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_value_done) |-> (m_status == STAT_OK))
        else $error("value done with error");
`endif
endmodule
`default_nettype wire

/* sv/mpvd_datapath.sv */
`default_nettype none
module mpvd_datapath
    import mpvd_pkg::*;
#(
    parameter int unsigned MAX_NEST = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire mpvd_cmd_t   cmd,
    output mpvd_stat_t       stat,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    output logic             done_o,
    output logic [1:0]       status_o,
    output logic [4:0]       level_o
);
    localparam int unsigned LVL_W = $clog2(MAX_NEST + 1);
    localparam int unsigned IDX_W = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    logic [CNT_W-1:0] stack_reg [MAX_NEST];
    logic [LVL_W-1:0] level_reg, level_next;
    logic [2:0]       phase_reg, phase_next;
    logic [2:0]       lbytes_reg, lbytes_next;
    logic [31:0]      accum_reg, accum_next;
    logic [31:0]      body_reg, body_next;
    logic             ext_reg, ext_next;
    kind_t            kind_reg, kind_next;
    logic [1:0]       err_reg, err_next;
    logic             done_reg, done_next;
    logic             pop_reg, pop_next;
    logic [7:0]       byte_reg;
    logic             last_reg;

    logic             push_en;
    logic [CNT_W-1:0] push_val;
    logic             top_wr;
    logic [CNT_W-1:0] top_val;
    logic [1:0]       fin_status;

    logic [1:0]       status_reg;
    logic [4:0]       olevel_reg;
    logic             odone_reg;

    localparam logic [2:0] PH_TAG = 3'd0, PH_LEN = 3'd1, PH_EXT = 3'd2, PH_BODY = 3'd3;

    logic [IDX_W-1:0] top_idx;
    logic [IDX_W-1:0] push_idx;
    logic [CNT_W-1:0] top_dec;
    tag_dec_t         dec;
    logic [31:0]      acc_shift;

    assign top_idx   = IDX_W'(level_reg - LVL_W'(1));
    assign push_idx  = IDX_W'(level_reg);
    assign top_dec   = stack_reg[top_idx] - CNT_W'(1);
    assign dec       = decode_tag(byte_reg);
    assign acc_shift = {accum_reg[23:0], byte_reg};
    assign stat.pop_pending = pop_reg;

    always_comb begin
        logic             open_c;
        logic [CNT_W-1:0] open_n;
        logic             body_c;
        logic [31:0]      body_n;
        logic             compl;
        open_c = 1'b0;
        open_n = '0;
        body_c = 1'b0;
        body_n = '0;
        compl  = 1'b0;
        level_next  = level_reg;
        phase_next  = phase_reg;
        lbytes_next = lbytes_reg;
        accum_next  = accum_reg;
        body_next   = body_reg;
        ext_next    = ext_reg;
        kind_next   = kind_reg;
        err_next    = err_reg;
        done_next   = done_reg;
        pop_next    = 1'b0;
        push_en     = 1'b0;
        push_val    = '0;
        top_wr      = 1'b0;
        top_val     = top_dec;

        if (cmd.do_byte) begin
            done_next = 1'b0;
            if (err_reg == STAT_OK) begin
                case (phase_reg)
                    PH_LEN: begin
                        accum_next = acc_shift;
                        if (lbytes_reg <= 3'd1) begin
                            lbytes_next = 3'd0;
                            if (kind_reg == KIND_ARRAY) begin
                                open_c = 1'b1;
                                open_n = {1'b0, acc_shift};
                            end else if (kind_reg == KIND_MAP) begin
                                open_c = 1'b1;
                                open_n = {acc_shift, 1'b0};
                            end else if (ext_reg) begin
                                body_next  = acc_shift;
                                phase_next = PH_EXT;
                            end else begin
                                body_c = 1'b1;
                                body_n = acc_shift;
                            end
                        end else begin
                            lbytes_next = lbytes_reg - 3'd1;
                        end
                    end
                    PH_EXT: begin
                        ext_next = 1'b0;
                        body_c = 1'b1;
                        body_n = body_reg;
                    end
                    PH_BODY: begin
                        if (body_reg <= 32'd1) begin
                            body_next = '0;
                            compl = 1'b1;
                        end else begin
                            body_next = body_reg - 32'd1;
                        end
                    end
                    default: begin
                        case (dec.act)
                            ACT_SCALAR: compl = 1'b1;
                            ACT_OPEN: begin
                                open_c = 1'b1;
                                open_n = CNT_W'(dec.count);
                            end
                            ACT_BODY: begin
                                body_c = 1'b1;
                                body_n = 32'(dec.count);
                            end
                            ACT_LEN: begin
                                lbytes_next = dec.nbytes;
                                accum_next  = '0;
                                kind_next   = dec.kind;
                                ext_next    = dec.ext;
                                phase_next  = PH_LEN;
                            end
                            default: err_next = STAT_BAD_TAG;
                        endcase
                    end
                endcase
                if (body_c) begin
                    if (body_n == 32'd0) begin
                        compl = 1'b1;
                    end else begin
                        body_next  = body_n;
                        phase_next = PH_BODY;
                    end
                end
                if (open_c) begin
                    if (open_n == '0) begin
                        compl = 1'b1;
                    end else if (level_reg >= LVL_W'(MAX_NEST)) begin
                        err_next = STAT_OVERFLOW;
                    end else begin
                        push_en    = 1'b1;
                        push_val   = open_n;
                        level_next = level_reg + LVL_W'(1);
                        phase_next = PH_TAG;
                    end
                end
                if (compl) begin
                    phase_next = PH_TAG;
                    if (level_reg == '0) begin
                        done_next = 1'b1;
                    end else begin
                        pop_next = 1'b1;
                    end
                end
            end
        end

        // one level per cycle: decrement the top count, drop it when exhausted; at level zero mark the value done
        if (cmd.do_pop) begin
            if (level_reg == '0) begin
                done_next = 1'b1;
            end else if (top_dec == '0) begin
                level_next = level_reg - LVL_W'(1);
                pop_next   = 1'b1;
            end else begin
                top_wr = 1'b1;
            end
        end

        if (cmd.frame_end) begin
            if (last_reg && err_reg == STAT_OK &&
                (phase_reg != PH_TAG || level_reg != '0)) begin
                err_next = STAT_TRUNC;
            end
        end
        // status reported for this byte, taken before the frame end clear
        fin_status = err_next;
        if (cmd.out_load && last_reg) begin
            level_next  = '0;
            phase_next  = PH_TAG;
            lbytes_next = '0;
            accum_next  = '0;
            body_next   = '0;
            ext_next    = 1'b0;
            kind_next   = KIND_BODY;
            err_next    = STAT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= '0;
            phase_reg  <= PH_TAG;
            lbytes_reg <= '0;
            accum_reg  <= '0;
            body_reg   <= '0;
            ext_reg    <= 1'b0;
            kind_reg   <= KIND_BODY;
            err_reg    <= STAT_OK;
            done_reg   <= 1'b0;
            pop_reg    <= 1'b0;
        end else begin
            level_reg  <= level_next;
            phase_reg  <= phase_next;
            lbytes_reg <= lbytes_next;
            accum_reg  <= accum_next;
            body_reg   <= body_next;
            ext_reg    <= ext_next;
            kind_reg   <= kind_next;
            err_reg    <= err_next;
            done_reg   <= done_next;
            pop_reg    <= pop_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_byte) begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (push_en) begin
            stack_reg[push_idx] <= push_val;
        end
        if (top_wr) begin
            stack_reg[top_idx] <= top_val;
        end
        if (cmd.out_load) begin
            odone_reg  <= done_reg;
            status_reg <= fin_status;
            olevel_reg <= 5'(level_reg);
        end
    end

    assign done_o   = odone_reg;
    assign status_o = status_reg;
    assign level_o  = olevel_reg;

`ifndef SYNTH
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_W'(MAX_NEST))
        else $error("nesting level beyond stack depth");
    a_push_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push_en && cmd.do_pop))
        else $error("push and pop in one cycle");
    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.do_byte && err_reg != STAT_OK) |=> !pop_reg && !done_reg)
        else $error("activity while error held");
`endif
endmodule
`default_nettype wire

/* sv/mpvd_ctrl.sv */
`default_nettype none
module mpvd_ctrl
    import mpvd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire mpvd_stat_t stat,
    output mpvd_cmd_t       cmd
);
    state_t  state_reg, state_next;
    logic    mvalid_reg, mvalid_next;
    logic    free;

    assign free    = !mvalid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_WORK;
            ST_WORK: state_next = ST_POP;
            ST_POP:  if (!stat.pop_pending) state_next = ST_FIN;
            ST_FIN:  if (free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        mvalid_next = mvalid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: cmd.take_byte = s_valid;
            ST_WORK: cmd.do_byte = 1'b1;
            ST_POP:  cmd.do_pop = stat.pop_pending;
            ST_FIN: begin
                cmd.frame_end = 1'b1;
                if (free) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

`ifndef SYNTH
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!mvalid_reg || m_ready))
        else $error("result overwritten");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.take_byte, cmd.do_byte, cmd.do_pop, cmd.frame_end}) <= 1)
        else $error("conflicting commands");
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not shown");
`endif
endmodule
`default_nettype wire
